>>> hdl/flt_pkg.sv
package flt_pkg;

    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 16;
    localparam int COUNT_BITS     = 16;
    localparam int TIME_BITS      = 32;
    localparam int IN_KEY_BITS    = 32;
    localparam int OUTCOME_BITS   = 2;
    // 65535 minutes * 60 fits in 22 bits
    localparam int WIN_BITS       = 22;

    localparam logic [CFG_INDEX_BITS-1:0] REG_REFUSE_MINUTES = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FAIL_THRESHOLD = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SECURE_MODE    = 2'd2;

    localparam logic [OUTCOME_BITS-1:0] OUTCOME_SUCCESS = 2'd0;
    localparam logic [OUTCOME_BITS-1:0] OUTCOME_FAILURE = 2'd1;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_EVAL,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic load;
        logic scan;
        logic clear_wr;
        logic eval;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic idx_last;
    } status_t;

endpackage

>>> hdl/flt_ctrl.sv
module flt_ctrl
    import flt_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  status_t status,
    output cmd_t    cmd,
    output logic    busy,
    output logic    done
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (status.idx_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (status.idx_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:  state_next = ST_EVAL;
            ST_EVAL:   state_next = ST_FINISH;
            ST_FINISH: state_next = ST_IDLE;
            default:   state_next = ST_CLEAR;
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        done = 1'b0;
        case (state_reg)
            ST_CLEAR: cmd.clear_wr = 1'b1;
            ST_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            ST_SCAN:  cmd.scan = 1'b1;
            ST_DRAIN: cmd = '0;
            ST_EVAL:  cmd.eval = 1'b1;
            ST_FINISH:
            begin
                cmd.finish = 1'b1;
                done       = 1'b1;
            end
            default:  cmd = '0;
        endcase
    end

endmodule

>>> hdl/flt_datapath.sv
module flt_datapath
    import flt_pkg::*;
#(
    parameter int TABLE_ENTRIES = 16,
    parameter int KEY_BITS      = 32
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  cmd_t                      cmd,
    output status_t                   status,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    input  logic [IN_KEY_BITS-1:0]    user_key,
    input  logic [OUTCOME_BITS-1:0]   outcome,
    input  logic [TIME_BITS-1:0]      now_seconds,
    output logic                      refused,
    output logic [COUNT_BITS-1:0]     fail_total,
    output logic                      table_full
);

    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [IW-1:0] IDX_LAST = IW'(TABLE_ENTRIES - 1);

    // table storage
    logic                  valid_mem [TABLE_ENTRIES];
    logic [KEY_BITS-1:0]   key_mem   [TABLE_ENTRIES];
    logic [COUNT_BITS-1:0] count_mem [TABLE_ENTRIES];
    logic [TIME_BITS-1:0]  last_mem  [TABLE_ENTRIES];

    logic                  rd_valid_reg;
    logic [KEY_BITS-1:0]   rd_key_reg;
    logic [COUNT_BITS-1:0] rd_count_reg;
    logic [TIME_BITS-1:0]  rd_last_reg;

    logic                  mem_we;
    logic [IW-1:0]         wr_idx;
    logic                  wr_valid;
    logic [COUNT_BITS-1:0] wr_count;
    logic [TIME_BITS-1:0]  wr_last;

    // config
    logic [CFG_DATA_BITS-1:0] refuse_minutes_reg;
    logic [CFG_DATA_BITS-1:0] fail_threshold_reg;
    logic                     secure_mode_reg;

    // latched input word
    logic [KEY_BITS-1:0]     key_reg;
    logic [OUTCOME_BITS-1:0] outcome_reg;
    logic [TIME_BITS-1:0]    now_reg;

    logic [IW-1:0] idx_reg;
    logic          rd_vld_reg;
    logic [IW-1:0] rd_idx_reg;

    logic                  hit_reg;
    logic [IW-1:0]         hit_idx_reg;
    logic [COUNT_BITS-1:0] hit_count_reg;
    logic [TIME_BITS-1:0]  hit_last_reg;
    logic                  free_reg;
    logic [IW-1:0]         free_idx_reg;

    logic          ins_pending_reg;
    logic [IW-1:0] ins_idx_reg;

    logic                  refused_reg;
    logic [COUNT_BITS-1:0] fail_total_reg;
    logic                  table_full_reg;

    assign status.idx_last = (idx_reg == IDX_LAST);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            refuse_minutes_reg <= '0;
            fail_threshold_reg <= '0;
            secure_mode_reg    <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_REFUSE_MINUTES: refuse_minutes_reg <= cfg_data;
                REG_FAIL_THRESHOLD: fail_threshold_reg <= cfg_data;
                REG_SECURE_MODE:    secure_mode_reg    <= cfg_data[0];
                default:            ;
            endcase
        end
    end

    // index counter, shared by the clearing sweep and the search
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= cmd.scan;
            if (cmd.load)
            begin
                idx_reg <= '0;
            end
            else if (cmd.scan || cmd.clear_wr)
            begin
                idx_reg <= status.idx_last ? '0 : idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg <= idx_reg;
        if (cmd.load)
        begin
            key_reg     <= KEY_BITS'(user_key);
            outcome_reg <= outcome;
            now_reg     <= now_seconds;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_valid_reg <= valid_mem[idx_reg];
        rd_key_reg   <= key_mem[idx_reg];
        rd_count_reg <= count_mem[idx_reg];
        rd_last_reg  <= last_mem[idx_reg];
        if (mem_we)
        begin
            valid_mem[wr_idx] <= wr_valid;
            key_mem[wr_idx]   <= key_reg;
            count_mem[wr_idx] <= wr_count;
            last_mem[wr_idx]  <= wr_last;
        end
    end

    // first matching entry and lowest free entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg  <= 1'b0;
            free_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            hit_reg  <= 1'b0;
            free_reg <= 1'b0;
        end
        else if (rd_vld_reg)
        begin
            if (rd_valid_reg && (rd_key_reg == key_reg) && !hit_reg)
            begin
                hit_reg <= 1'b1;
            end
            if (!rd_valid_reg && !free_reg)
            begin
                free_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_vld_reg && rd_valid_reg && (rd_key_reg == key_reg) && !hit_reg)
        begin
            hit_idx_reg   <= rd_idx_reg;
            hit_count_reg <= rd_count_reg;
            hit_last_reg  <= rd_last_reg;
        end
        if (rd_vld_reg && !rd_valid_reg && !free_reg)
        begin
            free_idx_reg <= rd_idx_reg;
        end
    end

    // decision
    logic [WIN_BITS-1:0]   window;
    logic [COUNT_BITS:0]   threshold;
    logic [TIME_BITS-1:0]  elapsed;
    logic                  is_fail;
    logic                  is_succ;
    logic                  active;
    logic                  over;
    logic                  in_window;
    logic                  refuse;
    logic                  stale;
    logic                  live;
    logic [COUNT_BITS-1:0] count_inc;
    logic                  can_insert;
    logic [IW-1:0]         ins_idx;
    logic                  need_insert;
    logic                  ev_we;
    logic                  ev_update;
    logic [COUNT_BITS-1:0] total;

    always_comb
    begin
        window    = (WIN_BITS'(refuse_minutes_reg) << 6) - (WIN_BITS'(refuse_minutes_reg) << 2);
        threshold = secure_mode_reg ? {fail_threshold_reg, 1'b0} : {1'b0, fail_threshold_reg};
        elapsed   = (now_reg >= hit_last_reg) ? now_reg - hit_last_reg : '0;
        is_fail   = (outcome_reg == OUTCOME_FAILURE);
        is_succ   = (outcome_reg == OUTCOME_SUCCESS);
        active    = is_fail || is_succ;
        over      = ({1'b0, hit_count_reg} >= threshold);
        in_window = (elapsed < TIME_BITS'(window));
        refuse    = active && hit_reg && over && in_window;
        // at/over threshold: stale once the window is reached; under: once exceeded
        stale     = active && hit_reg && !refuse
                    && (over ? !in_window : (elapsed > TIME_BITS'(window)));
        live      = hit_reg && !stale;
        count_inc = (hit_count_reg == COUNT_MAX) ? hit_count_reg : hit_count_reg + 1'b1;

        can_insert = free_reg || stale;
        if (stale && (!free_reg || (hit_idx_reg < free_idx_reg)))
        begin
            ins_idx = hit_idx_reg;
        end
        else
        begin
            ins_idx = free_idx_reg;
        end
        need_insert = is_fail && !refuse && !live && can_insert;

        ev_update = is_fail && !refuse && live;
        ev_we     = stale || ev_update || (is_succ && !refuse && live);

        total = '0;
        if (!active)
        begin
            total = hit_reg ? hit_count_reg : '0;
        end
        else if (refuse)
        begin
            total = hit_count_reg;
        end
        else if (ev_update)
        begin
            total = count_inc;
        end
        else if (need_insert)
        begin
            total = COUNT_BITS'(1);
        end
    end

    always_comb
    begin
        mem_we   = 1'b0;
        wr_idx   = idx_reg;
        wr_valid = 1'b0;
        wr_count = '0;
        wr_last  = '0;
        if (cmd.clear_wr)
        begin
            mem_we = 1'b1;
        end
        else if (cmd.eval)
        begin
            mem_we   = ev_we;
            wr_idx   = hit_idx_reg;
            wr_valid = ev_update;
            wr_count = count_inc;
            wr_last  = now_reg;
        end
        else if (cmd.finish)
        begin
            mem_we   = ins_pending_reg;
            wr_idx   = ins_idx_reg;
            wr_valid = 1'b1;
            wr_count = COUNT_BITS'(1);
            wr_last  = now_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ins_pending_reg <= 1'b0;
        end
        else if (cmd.eval)
        begin
            ins_pending_reg <= need_insert;
        end
        else if (cmd.finish)
        begin
            ins_pending_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.eval)
        begin
            ins_idx_reg    <= ins_idx;
            refused_reg    <= refuse;
            fail_total_reg <= total;
            table_full_reg <= is_fail && !refuse && !live && !can_insert;
        end
    end

    assign refused    = refused_reg;
    assign fail_total = fail_total_reg;
    assign table_full = table_full_reg;

endmodule

>>> hdl/failed_login_lockout_table.sv
// Failed-login lockout table.
// Input: a word (user_key, outcome, now_seconds) is taken at a rising edge with
// start high and busy low. busy stays high until the result has been shown.
// Output: refused, fail_total and table_full are valid while done is high,
// for exactly one cycle; the receiver cannot stall, so nothing waits on it.
// Configuration: cfg_we writes cfg_data into register cfg_index
// (0 refuse_minutes, 1 fail_threshold, 2 secure_mode) at once; write while idle.
// Operation: each event runs a linear search of the table memory, one entry
// per cycle through its single registered read port, then a drain state, an
// evaluate state and a finish state that holds the insert write; the block
// returns to idle before the next start is taken.
// Reset: config registers go to zero, then a clearing pass over all TABLE_ENTRIES
// entries marks every entry free; busy is high during the pass.
module failed_login_lockout_table
    import flt_pkg::*;
#(
    parameter int TABLE_ENTRIES = 16,
    parameter int KEY_BITS      = 32
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [IN_KEY_BITS-1:0]    user_key,
    input  logic [OUTCOME_BITS-1:0]   outcome,
    input  logic [TIME_BITS-1:0]      now_seconds,
    output logic                      done,
    output logic                      refused,
    output logic [COUNT_BITS-1:0]     fail_total,
    output logic                      table_full,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

    cmd_t    cmd;
    status_t status;

    flt_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    flt_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .KEY_BITS      (KEY_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .user_key    (user_key),
        .outcome     (outcome),
        .now_seconds (now_seconds),
        .refused     (refused),
        .fail_total  (fail_total),
        .table_full  (table_full)
    );

endmodule

>>> tb/sv/failed_login_lockout_table_checker.sv
`timescale 1ns / 1ps
module failed_login_lockout_table_checker
    import flt_pkg::*;
#(
    parameter int TABLE_ENTRIES = 16
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic                      busy,
    input  logic [IN_KEY_BITS-1:0]    user_key,
    input  logic [OUTCOME_BITS-1:0]   outcome,
    input  logic [TIME_BITS-1:0]      now_seconds,
    input  logic                      done,
    input  logic                      refused,
    input  logic [COUNT_BITS-1:0]     fail_total,
    input  logic                      table_full,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    output int                        mismatches,
    output int                        pending
);

    typedef struct packed {
        logic                  refused;
        logic [COUNT_BITS-1:0] total;
        logic                  full;
    } verdict_t;

    logic [CFG_DATA_BITS-1:0] window_minutes;
    logic [CFG_DATA_BITS-1:0] threshold_base;
    logic                     secure;

    logic                   slot_used  [TABLE_ENTRIES];
    logic [IN_KEY_BITS-1:0] slot_key   [TABLE_ENTRIES];
    logic [COUNT_BITS-1:0]  slot_count [TABLE_ENTRIES];
    logic [TIME_BITS-1:0]   slot_stamp [TABLE_ENTRIES];

    verdict_t owed_verdicts[$];
    verdict_t want;
    int       fault_count;

    // Applies one login event to the shadow table and returns the verdict word.
    function automatic verdict_t judge_login(input logic [IN_KEY_BITS-1:0]  key,
                                             input logic [OUTCOME_BITS-1:0] code,
                                             input logic [TIME_BITS-1:0]    now);
        verdict_t                v;
        int                      hit;
        int                      free_slot;
        logic [CFG_DATA_BITS:0]  limit;
        logic [TIME_BITS-1:0]    window;
        logic [TIME_BITS-1:0]    elapsed;
        v = '0;
        hit = -1;
        free_slot = -1;
        limit = secure ? {threshold_base, 1'b0} : {1'b0, threshold_base};
        window = window_minutes * 32'd60;
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            if (hit < 0 && slot_used[i] && slot_key[i] == key)
                hit = i;
        end
        if (code != OUTCOME_SUCCESS && code != OUTCOME_FAILURE)
        begin
            if (hit >= 0)
                v.total = slot_count[hit];
            return v;
        end
        if (hit >= 0)
        begin
            // clock stepped back counts as no time passed
            elapsed = (now >= slot_stamp[hit]) ? now - slot_stamp[hit] : '0;
            if (slot_count[hit] >= limit)
            begin
                if (elapsed < window)
                begin
                    v.refused = 1'b1;
                    v.total = slot_count[hit];
                    return v;
                end
                slot_used[hit] = 1'b0;
                hit = -1;
            end
            else if (elapsed > window)
            begin
                slot_used[hit] = 1'b0;
                hit = -1;
            end
        end
        if (code == OUTCOME_FAILURE)
        begin
            if (hit >= 0)
            begin
                if (slot_count[hit] != COUNT_MAX)
                    slot_count[hit] = slot_count[hit] + 1'b1;
                slot_stamp[hit] = now;
                v.total = slot_count[hit];
            end
            else
            begin
                for (int i = TABLE_ENTRIES - 1; i >= 0; i--)
                begin
                    if (!slot_used[i])
                        free_slot = i;
                end
                if (free_slot < 0)
                    v.full = 1'b1;
                else
                begin
                    slot_used[free_slot]  = 1'b1;
                    slot_key[free_slot]   = key;
                    slot_count[free_slot] = COUNT_BITS'(1);
                    slot_stamp[free_slot] = now;
                    v.total = COUNT_BITS'(1);
                end
            end
        end
        else if (hit >= 0)
            slot_used[hit] = 1'b0;
        return v;
    endfunction

    task automatic note_fault(input string what, input longint unsigned expected_val,
                              input longint unsigned actual_val);
        fault_count++;
        $display("%0t: %s mismatch, expected %0d, actual %0d",
                 $time, what, expected_val, actual_val);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_minutes = '0;
            threshold_base = '0;
            secure = 1'b0;
            for (int i = 0; i < TABLE_ENTRIES; i++)
                slot_used[i] = 1'b0;
            owed_verdicts.delete();
            fault_count = 0;
            mismatches <= 0;
            pending <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_REFUSE_MINUTES: window_minutes = cfg_data;
                    REG_FAIL_THRESHOLD: threshold_base = cfg_data;
                    REG_SECURE_MODE:    secure = cfg_data[0];
                    default: ;
                endcase
            end
            if (done)
            begin
                if (owed_verdicts.size() == 0)
                    note_fault("unexpected result word, fail_total", 0, fail_total);
                else
                begin
                    want = owed_verdicts.pop_front();
                    if (refused !== want.refused)
                        note_fault("refused", want.refused, refused);
                    if (fail_total !== want.total)
                        note_fault("fail_total", want.total, fail_total);
                    if (table_full !== want.full)
                        note_fault("table_full", want.full, table_full);
                end
            end
            if (start && !busy)
                owed_verdicts.push_back(judge_login(user_key, outcome, now_seconds));
            mismatches <= fault_count;
            pending <= owed_verdicts.size();
        end
    end

endmodule

>>> tb/sv/failed_login_lockout_table_tb.sv
`timescale 1ns / 1ps
module failed_login_lockout_table_tb;
    import flt_pkg::*;

    localparam int TABLE_ENTRIES = 16;
    localparam int KEY_BITS      = 32;
    localparam int KEY_POOL      = 20;
    localparam int QUIET_LIMIT   = 4000;

    localparam logic [OUTCOME_BITS-1:0] OUTCOME_OTHER = 2'd2;
    localparam logic [OUTCOME_BITS-1:0] OUTCOME_SPARE = 2'd3;

    localparam logic [IN_KEY_BITS-1:0] USER_A = 32'h1234_5678;
    localparam logic [IN_KEY_BITS-1:0] USER_B = 32'hA5C3_0F96;
    localparam logic [IN_KEY_BITS-1:0] USER_C = 32'h0000_8001;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      start;
    logic                      busy;
    logic [IN_KEY_BITS-1:0]    user_key;
    logic [OUTCOME_BITS-1:0]   outcome;
    logic [TIME_BITS-1:0]      now_seconds;
    logic                      done;
    logic                      refused;
    logic [COUNT_BITS-1:0]     fail_total;
    logic                      table_full;
    logic                      cfg_we;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;

    int mismatches;
    int pending;
    int quiet_cycles = 0;

    logic [TIME_BITS-1:0]     clock_now;
    logic [CFG_DATA_BITS-1:0] cur_minutes;
    logic                     no_gaps;
    logic [IN_KEY_BITS-1:0]   user_pool  [KEY_POOL];
    logic [TIME_BITS-1:0]     user_stamp [KEY_POOL];

    failed_login_lockout_table #(
        .TABLE_ENTRIES(TABLE_ENTRIES),
        .KEY_BITS(KEY_BITS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .user_key(user_key),
        .outcome(outcome),
        .now_seconds(now_seconds),
        .done(done),
        .refused(refused),
        .fail_total(fail_total),
        .table_full(table_full),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    failed_login_lockout_table_checker #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) lockout_check (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .user_key(user_key),
        .outcome(outcome),
        .now_seconds(now_seconds),
        .done(done),
        .refused(refused),
        .fail_total(fail_total),
        .table_full(table_full),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .mismatches(mismatches),
        .pending(pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done || cfg_we || !rst_n)
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (no_gaps || roll < 50)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 95)
            return $urandom_range(4, 20);
        return $urandom_range(30, 60);
    endfunction

    task automatic send_login(input logic [IN_KEY_BITS-1:0]  key,
                              input logic [OUTCOME_BITS-1:0] code,
                              input logic [TIME_BITS-1:0]    stamp);
        int gap;
        gap = pick_gap();
        start <= 1'b1;
        user_key <= key;
        outcome <= code;
        now_seconds <= stamp;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic settle();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0 || busy)
            @(posedge clk);
    endtask

    task automatic apply_settings(input logic [CFG_DATA_BITS-1:0] minutes,
                                  input logic [CFG_DATA_BITS-1:0] threshold,
                                  input logic                     secure);
        logic [CFG_DATA_BITS-1:0] junk;
        junk = CFG_DATA_BITS'($urandom());
        settle();
        cfg_we <= 1'b1;
        cfg_index <= REG_REFUSE_MINUTES;
        cfg_data <= minutes;
        @(posedge clk);
        cfg_index <= REG_FAIL_THRESHOLD;
        cfg_data <= threshold;
        @(posedge clk);
        // upper bits of the mode word are don't-care
        cfg_index <= REG_SECURE_MODE;
        cfg_data <= {junk[CFG_DATA_BITS-1:1], secure};
        @(posedge clk);
        cfg_we <= 1'b0;
        cur_minutes = minutes;
    endtask

    // Random events over a pool of users, often staying on one user, with times often pushed around the window edge.
    task automatic run_phase(input int items, input int pool_size);
        int                      idx;
        int                      roll;
        int                      sent;
        logic [OUTCOME_BITS-1:0] code;
        logic [TIME_BITS-1:0]    window;
        idx = 0;
        sent = 0;
        window = cur_minutes * 32'd60;
        no_gaps = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < pool_size; i++)
        begin
            user_pool[i] = $urandom();
            user_stamp[i] = clock_now;
        end
        if ($urandom_range(0, 1) == 1)
        begin
            user_pool[0] = '0;
            user_pool[1] = '1;
        end
        while (sent < items)
        begin
            if ($urandom_range(0, 99) >= 55)
                idx = $urandom_range(0, pool_size - 1);
            roll = $urandom_range(0, 99);
            if (roll < 55)
                code = OUTCOME_FAILURE;
            else if (roll < 85)
                code = OUTCOME_SUCCESS;
            else if (roll < 93)
                code = OUTCOME_OTHER;
            else
                code = OUTCOME_SPARE;
            roll = $urandom_range(0, 99);
            if (roll < 55)
                clock_now = clock_now + $urandom_range(0, window / 3 + 2);
            else if (roll < 80)
                clock_now = user_stamp[idx] + window + $urandom_range(0, 2) - 1;
            else if (roll < 90)
                clock_now = clock_now - $urandom_range(0, 1000);
            else
                clock_now = $urandom();
            if (code == OUTCOME_FAILURE)
                user_stamp[idx] = clock_now;
            send_login(user_pool[idx], code, clock_now);
            sent++;
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        user_key = '0;
        outcome = OUTCOME_SUCCESS;
        now_seconds = '0;
        cfg_we = 1'b0;
        cfg_index = REG_REFUSE_MINUTES;
        cfg_data = '0;
        no_gaps = 1'b0;
        cur_minutes = '0;
        clock_now = 32'd10000;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);

        // 60 s window, three strikes
        apply_settings(16'd1, 16'd3, 1'b0);
        send_login(USER_A, OUTCOME_OTHER, 32'd500);
        send_login(USER_A, OUTCOME_SPARE, 32'd500);
        send_login(USER_A, OUTCOME_SUCCESS, 32'd500);
        send_login(USER_A, OUTCOME_FAILURE, 32'd1000);
        send_login(USER_A, OUTCOME_FAILURE, 32'd1010);
        send_login(USER_A, OUTCOME_FAILURE, 32'd1020);
        send_login(USER_A, OUTCOME_SPARE, 32'd1025);
        send_login(USER_A, OUTCOME_FAILURE, 32'd1030);
        send_login(USER_A, OUTCOME_SUCCESS, 32'd1079);
        // locked entry expires exactly at the window
        send_login(USER_A, OUTCOME_SUCCESS, 32'd1080);
        send_login(USER_B, OUTCOME_FAILURE, 32'd5000);
        // unlocked entry only goes stale strictly past the window
        send_login(USER_B, OUTCOME_FAILURE, 32'd5061);
        send_login(USER_B, OUTCOME_FAILURE, 32'd5121);
        send_login(USER_B, OUTCOME_FAILURE, 32'd4000);
        send_login(USER_B, OUTCOME_SUCCESS, 32'd4000);
        send_login(32'h0000_0000, OUTCOME_FAILURE, 32'h0000_0000);
        send_login(32'hFFFF_FFFF, OUTCOME_FAILURE, 32'hFFFF_FFFF);
        send_login(32'h0000_0000, OUTCOME_SUCCESS, 32'hFFFF_FFFF);
        send_login(32'hFFFF_FFFF, OUTCOME_FAILURE, 32'h0000_0000);
        // zero threshold refuses any present user in the window
        apply_settings(16'd1, 16'd0, 1'b0);
        send_login(USER_B, OUTCOME_FAILURE, 32'd4010);
        // zero window never refuses
        apply_settings(16'd0, 16'd3, 1'b0);
        send_login(USER_B, OUTCOME_FAILURE, 32'd4020);
        // secure link doubles the threshold to four
        apply_settings(16'd1, 16'd2, 1'b1);
        send_login(USER_C, OUTCOME_FAILURE, 32'd7000);
        send_login(USER_C, OUTCOME_FAILURE, 32'd7001);
        send_login(USER_C, OUTCOME_FAILURE, 32'd7002);
        send_login(USER_C, OUTCOME_FAILURE, 32'd7003);
        send_login(USER_C, OUTCOME_SUCCESS, 32'd7004);

        apply_settings(16'd5, 16'd4, 1'b1);
        run_phase(70, 6);
        apply_settings(16'd0, 16'd2, 1'b0);
        run_phase(50, 6);
        apply_settings(16'd2, 16'd0, 1'b0);
        run_phase(50, 6);
        apply_settings(16'd1, 16'd1, 1'b0);
        run_phase(60, 8);
        // huge window and unreachable threshold: the table fills up
        apply_settings(16'hFFFF, 16'hFFFF, 1'b1);
        run_phase(70, KEY_POOL);
        apply_settings(16'd0, 16'd0, 1'b0);
        run_phase(40, 10);
        apply_settings(CFG_DATA_BITS'($urandom_range(1, 10)),
                       CFG_DATA_BITS'($urandom_range(1, 6)),
                       1'($urandom_range(0, 1)));
        run_phase(60, 6);
        apply_settings(CFG_DATA_BITS'($urandom_range(0, 65535)),
                       CFG_DATA_BITS'($urandom_range(0, 65535)),
                       1'($urandom_range(0, 1)));
        run_phase(60, 12);
        apply_settings(16'd3, 16'hFFFF, 1'b0);
        run_phase(60, KEY_POOL);

        settle();
        repeat (2 * (TABLE_ENTRIES + 4)) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

>>> filelist.f
hdl/flt_pkg.sv
hdl/flt_ctrl.sv
hdl/flt_datapath.sv
hdl/failed_login_lockout_table.sv
tb/sv/failed_login_lockout_table_checker.sv
tb/sv/failed_login_lockout_table_tb.sv
